/* rtl/core/abag_pkg.sv */
package abag_pkg;

  // Fixed-point format: FRAC_BITS fraction bits, ONE stands for 1.0.
  localparam int FRAC_BITS  = 16;
  localparam int MEAS_WIDTH = 16;
  localparam int ONE        = 1 << FRAC_BITS;

  // Field widths, all derived from the fraction width.
  localparam int SETP_W  = FRAC_BITS;      // setpoint
  localparam int ALPHA_W = FRAC_BITS;      // filter coefficient
  localparam int LVL_W   = FRAC_BITS + 1;  // bands, steps, bias, gain, drive
  localparam int ERR_W   = FRAC_BITS + 2;  // filtered error, two's complement

  // Configuration port.
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = LVL_W;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SETPOINT  = 3'd0,
    REG_ALPHA     = 3'd1,
    REG_BIAS_BAND = 3'd2,
    REG_GAIN_BAND = 3'd3,
    REG_BIAS_STEP = 3'd4,
    REG_GAIN_STEP = 3'd5
  } cfg_reg_t;

  // Register values after reset.
  localparam logic [SETP_W-1:0]  RST_SETPOINT  = '0;
  localparam logic [ALPHA_W-1:0] RST_ALPHA     = ALPHA_W'(ONE * 3 / 4);
  localparam logic [LVL_W-1:0]   RST_BIAS_BAND = LVL_W'(ONE * 3 / 4);
  localparam logic [LVL_W-1:0]   RST_GAIN_BAND = LVL_W'(ONE / 2);
  localparam logic [LVL_W-1:0]   RST_BIAS_STEP = LVL_W'(ONE / 1024);
  localparam logic [LVL_W-1:0]   RST_GAIN_STEP = LVL_W'(ONE / 512);

endpackage

/* rtl/core/abag_in_if.sv */
interface abag_in_if #(
  parameter int MEAS_WIDTH = abag_pkg::MEAS_WIDTH
);
  logic                  valid;
  logic                  ready;
  logic [MEAS_WIDTH-1:0] measurement;

  modport source (output valid, output measurement, input ready);
  modport sink   (input valid, input measurement, output ready);
endinterface

/* rtl/core/abag_out_if.sv */
interface abag_out_if;
  logic                                valid;
  logic                                ready;
  logic        [abag_pkg::LVL_W-1:0]   drive;
  logic        [abag_pkg::LVL_W-1:0]   bias_now;
  logic        [abag_pkg::LVL_W-1:0]   gain_now;
  logic signed [abag_pkg::ERR_W-1:0]   error_now;

  modport source (output valid, output drive, output bias_now, output gain_now,
                  output error_now, input ready);
  modport sink   (input valid, input drive, input bias_now, input gain_now,
                  input error_now, output ready);
endinterface

/* rtl/core/abag_cfg_if.sv */
interface abag_cfg_if;
  logic                              valid;
  logic                              ready;
  logic [abag_pkg::CFG_IDX_W-1:0]    index;
  logic [abag_pkg::CFG_DATA_W-1:0]   data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

/* rtl/core/adaptive_bias_gain_controller_core.sv */
// Adaptive bias / adaptive gain controller, one measurement word per control tick.
// Each word passes the input register, then the result register, and is offered
// from the result register; a stall on the result side holds it where it is.
// Throughput: one word per cycle unless out_ch stalls; error filter, bias and gain
// are updated in the single result stage, so each word sees the state of the last.
// Reset (synchronous, rst_n low): stages empty, filter and levels cleared,
// configuration registers back to their default values.
module adaptive_bias_gain_controller_core #(
  parameter int MEAS_WIDTH = abag_pkg::MEAS_WIDTH
) (
  input  logic             clk,
  input  logic             rst_n,
  abag_in_if.sink          in_ch,
  abag_out_if.source       out_ch,
  abag_cfg_if.sink         cfg_ch
);

  localparam int FRAC_BITS = abag_pkg::FRAC_BITS;
  localparam int SETP_W    = abag_pkg::SETP_W;
  localparam int ALPHA_W   = abag_pkg::ALPHA_W;
  localparam int LVL_W     = abag_pkg::LVL_W;
  localparam int ERR_W     = abag_pkg::ERR_W;
  // Working width for sums: one bit above the error so nothing wraps.
  localparam int EW        = ERR_W + 1;
  localparam int PROD_W    = 2 * ERR_W;
  localparam int CMP_W     = (MEAS_WIDTH > SETP_W) ? MEAS_WIDTH : SETP_W;

  localparam logic signed [EW-1:0]     ONE_S     = EW'(abag_pkg::ONE);
  localparam logic signed [EW-1:0]     NEG_ONE_S = -ONE_S;
  localparam logic        [FRAC_BITS:0] ONE_U    = (FRAC_BITS + 1)'(abag_pkg::ONE);

  // Configuration registers.
  logic [SETP_W-1:0]  setpoint_r;
  logic [ALPHA_W-1:0] alpha_r;
  logic [LVL_W-1:0]   bias_band_r;
  logic [LVL_W-1:0]   gain_band_r;
  logic [LVL_W-1:0]   bias_step_r;
  logic [LVL_W-1:0]   gain_step_r;

  // Input stage.
  logic                  in_valid_r;
  logic [MEAS_WIDTH-1:0] meas_r;

  // Result stage. The bias, gain and error registers are also the controller
  // state: they only change when a new result word is loaded.
  logic                    out_valid_r;
  logic [LVL_W-1:0]        drive_r, drive_nxt;
  logic [LVL_W-1:0]        bias_r, bias_nxt;
  logic [LVL_W-1:0]        gain_r, gain_nxt;
  logic signed [ERR_W-1:0] err_r, err_nxt;

  logic advance;

  // The result stage can be loaded when it is empty or its word is leaving.
  assign advance      = !out_valid_r || out_ch.ready;
  assign in_ch.ready  = !in_valid_r || advance;
  assign cfg_ch.ready = 1'b1;

  // Configuration writes. Unknown indexes are ignored.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      setpoint_r  <= abag_pkg::RST_SETPOINT;
      alpha_r     <= abag_pkg::RST_ALPHA;
      bias_band_r <= abag_pkg::RST_BIAS_BAND;
      gain_band_r <= abag_pkg::RST_GAIN_BAND;
      bias_step_r <= abag_pkg::RST_BIAS_STEP;
      gain_step_r <= abag_pkg::RST_GAIN_STEP;
    end else if (cfg_ch.valid) begin
      case (abag_pkg::cfg_reg_t'(cfg_ch.index))
        abag_pkg::REG_SETPOINT:  setpoint_r  <= cfg_ch.data[SETP_W-1:0];
        abag_pkg::REG_ALPHA:     alpha_r     <= cfg_ch.data[ALPHA_W-1:0];
        abag_pkg::REG_BIAS_BAND: bias_band_r <= cfg_ch.data[LVL_W-1:0];
        abag_pkg::REG_GAIN_BAND: gain_band_r <= cfg_ch.data[LVL_W-1:0];
        abag_pkg::REG_BIAS_STEP: bias_step_r <= cfg_ch.data[LVL_W-1:0];
        abag_pkg::REG_GAIN_STEP: gain_step_r <= cfg_ch.data[LVL_W-1:0];
        default: ;
      endcase
    end
  end

  // Saturate a working-width value to the level range of zero to one.
  function automatic logic [LVL_W-1:0] sat_level(input logic signed [EW-1:0] v);
    logic [LVL_W-1:0] r;
    if (v < 0) begin
      r = '0;
    end else if (v > ONE_S) begin
      r = ONE_U;
    end else begin
      r = v[LVL_W-1:0];
    end
    return r;
  endfunction

  // Datapath of the result stage.
  logic                     above;
  logic signed [ERR_W-1:0]  alpha_s;
  logic signed [PROD_W-1:0] prod;
  logic signed [PROD_W-1:0] prod_shift;
  logic signed [EW-1:0]     filt_base;
  logic        [FRAC_BITS:0] rest;
  logic signed [EW-1:0]     rest_s;
  logic signed [EW-1:0]     filt_sum;
  logic signed [EW-1:0]     filt_sat;
  logic signed [EW-1:0]     bias_band_s, gain_band_s;
  logic signed [EW-1:0]     bias_s, gain_s;
  logic signed [EW-1:0]     bias_step_s, gain_step_s;
  logic signed [EW-1:0]     bias_sum, gain_sum;
  logic signed [EW-1:0]     bias_new_s, gain_new_s;
  logic signed [EW-1:0]     drive_sum;

  always_comb begin
    // The measurement is strictly above the setpoint: sign +1.
    above = CMP_W'(meas_r) > CMP_W'(setpoint_r);

    // The coefficient is always below one, so one minus it stays positive.
    alpha_s    = signed'({2'b00, alpha_r});
    prod       = alpha_s * err_r;
    // The arithmetic shift rounds towards minus infinity, as the filter needs.
    prod_shift = prod >>> FRAC_BITS;
    filt_base  = signed'(prod_shift[EW-1:0]);
    rest       = ONE_U - {1'b0, alpha_r};
    rest_s     = signed'({{(EW - FRAC_BITS - 1){1'b0}}, rest});
    filt_sum   = above ? (filt_base + rest_s) : (filt_base - rest_s);

    if (filt_sum > ONE_S) begin
      filt_sat = ONE_S;
    end else if (filt_sum < NEG_ONE_S) begin
      filt_sat = NEG_ONE_S;
    end else begin
      filt_sat = filt_sum;
    end
    err_nxt = filt_sat[ERR_W-1:0];

    bias_band_s = signed'({{(EW - LVL_W){1'b0}}, bias_band_r});
    gain_band_s = signed'({{(EW - LVL_W){1'b0}}, gain_band_r});
    bias_step_s = signed'({{(EW - LVL_W){1'b0}}, bias_step_r});
    gain_step_s = signed'({{(EW - LVL_W){1'b0}}, gain_step_r});
    bias_s      = signed'({{(EW - LVL_W){1'b0}}, bias_r});
    gain_s      = signed'({{(EW - LVL_W){1'b0}}, gain_r});

    // Bias steps down below the band, up above it and holds inside it.
    if (filt_sat < -bias_band_s) begin
      bias_sum = bias_s - bias_step_s;
    end else if (filt_sat > bias_band_s) begin
      bias_sum = bias_s + bias_step_s;
    end else begin
      bias_sum = bias_s;
    end
    bias_nxt = sat_level(bias_sum);

    // Gain grows while the error sits outside its band and shrinks inside.
    if ((filt_sat < -gain_band_s) || (filt_sat > gain_band_s)) begin
      gain_sum = gain_s + gain_step_s;
    end else begin
      gain_sum = gain_s - gain_step_s;
    end
    gain_nxt = sat_level(gain_sum);

    bias_new_s = signed'({{(EW - LVL_W){1'b0}}, bias_nxt});
    gain_new_s = signed'({{(EW - LVL_W){1'b0}}, gain_nxt});
    drive_sum  = above ? (bias_new_s + gain_new_s) : (bias_new_s - gain_new_s);
    drive_nxt  = sat_level(drive_sum);
  end

  // Input stage register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_ch.ready) begin
      in_valid_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.ready && in_ch.valid) begin
      meas_r <= in_ch.measurement;
    end
  end

  // Result stage and controller state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      bias_r      <= '0;
      gain_r      <= '0;
      err_r       <= '0;
    end else if (advance) begin
      out_valid_r <= in_valid_r;
      if (in_valid_r) begin
        bias_r <= bias_nxt;
        gain_r <= gain_nxt;
        err_r  <= err_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance && in_valid_r) begin
      drive_r <= drive_nxt;
    end
  end

  assign out_ch.valid     = out_valid_r;
  assign out_ch.drive     = drive_r;
  assign out_ch.bias_now  = bias_r;
  assign out_ch.gain_now  = gain_r;
  assign out_ch.error_now = err_r;

  // While a result word is held back, the controller state must not move on.
  a_state_holds_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_ch.ready) |=> ($stable(bias_r) && $stable(gain_r) &&
                                        $stable(err_r)))
    else $error("controller state changed while the result word was stalled");

  // A waiting input word is neither dropped nor overwritten.
  a_input_kept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid_r && !advance) |=> (in_valid_r && $stable(meas_r)))
    else $error("input word lost while the result stage was stalled");

  // Every offered word lies within the documented ranges.
  a_result_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> ((err_r <= signed'(ONE_S[ERR_W-1:0])) &&
                     (err_r >= signed'(NEG_ONE_S[ERR_W-1:0])) &&
                     (drive_r <= ONE_U) && (bias_r <= ONE_U) && (gain_r <= ONE_U)))
    else $error("result word out of range");

endmodule

/* tb/testbench.sv */
`timescale 1ns / 100ps

// Testbench for the adaptive bias / adaptive gain controller core.
//
// Measurement words go in on one channel. Result words (drive, bias, gain and
// filtered error) come out on another, one result word for each measurement
// word. A predictor in this module keeps its own copy of the configuration
// registers and of the filter, bias and gain state. For every measurement word
// that the core accepts, it works out the result word that the core must
// produce and queues it. A checking process compares every accepted result
// word, field by field, with the oldest queued expectation.
module testbench;

  localparam int FRAC_BITS  = abag_pkg::FRAC_BITS;
  localparam int MEAS_WIDTH = abag_pkg::MEAS_WIDTH;
  localparam int ONE        = abag_pkg::ONE;
  localparam int SETP_W     = abag_pkg::SETP_W;
  localparam int ALPHA_W    = abag_pkg::ALPHA_W;
  localparam int LVL_W      = abag_pkg::LVL_W;
  localparam int ERR_W      = abag_pkg::ERR_W;
  localparam int CFG_IDX_W  = abag_pkg::CFG_IDX_W;
  localparam int CFG_DATA_W = abag_pkg::CFG_DATA_W;

  // Register indexes that the core does not decode; writes to them must be
  // ignored.
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 3'd7;

  localparam int IDLE_PCT    = 18;      // chance of an idle cycle on either side
  localparam int CYCLE_LIMIT = 400000;  // far above the slowest correct run

  typedef struct packed {
    logic        [LVL_W-1:0] drive;
    logic        [LVL_W-1:0] bias_now;
    logic        [LVL_W-1:0] gain_now;
    logic signed [ERR_W-1:0] error_now;
  } tick_result_t;

  logic clk = 1'b0;
  logic rst_n;

  abag_in_if  in_if();
  abag_out_if out_if();
  abag_cfg_if cfg_if();

  adaptive_bias_gain_controller_core u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_if),
    .out_ch (out_if),
    .cfg_ch (cfg_if)
  );

  // Period of 12 ns: six high, six low.
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Predictor copy of the configuration registers, at their reset values.
  logic [SETP_W-1:0]  setp_q      = abag_pkg::RST_SETPOINT;
  logic [ALPHA_W-1:0] alpha_q     = abag_pkg::RST_ALPHA;
  logic [LVL_W-1:0]   bias_band_q = abag_pkg::RST_BIAS_BAND;
  logic [LVL_W-1:0]   gain_band_q = abag_pkg::RST_GAIN_BAND;
  logic [LVL_W-1:0]   bias_step_q = abag_pkg::RST_BIAS_STEP;
  logic [LVL_W-1:0]   gain_step_q = abag_pkg::RST_GAIN_STEP;

  // Predictor copy of the controller state, all cleared by reset.
  longint err_q  = 0;
  longint bias_q = 0;
  longint gain_q = 0;

  tick_result_t expected_words[$];

  int  fail_count = 0;
  int  cycle_count = 0;
  bit  idle_en = 1'b1;   // random idle cycles on both sides when set
  int  stall_left = 0;   // cycles for which the result side is held off

  function automatic longint clamp(input longint v, input longint lo, input longint hi);
    if (v < lo) return lo;
    if (v > hi) return hi;
    return v;
  endfunction

  // One control tick of the controller. The filter product is shifted
  // arithmetically, which rounds toward minus infinity as the block must.
  function automatic void predict_tick(input logic [MEAS_WIDTH-1:0] m);
    longint a;
    longint e;
    longint drv;
    bit up;
    tick_result_t r;
    up = (m > setp_q);
    a = clamp(longint'(alpha_q), 0, ONE);
    e = (a * err_q) >>> FRAC_BITS;
    e = up ? e + (ONE - a) : e - (ONE - a);
    e = clamp(e, -ONE, ONE);
    err_q = e;

    // The bias moves only when the filtered error leaves its band.
    if (e < -longint'(bias_band_q))
      bias_q -= longint'(bias_step_q);
    else if (e > longint'(bias_band_q))
      bias_q += longint'(bias_step_q);
    bias_q = clamp(bias_q, 0, ONE);

    // The gain grows outside its band and shrinks inside it.
    if (e < -longint'(gain_band_q) || e > longint'(gain_band_q))
      gain_q += longint'(gain_step_q);
    else
      gain_q -= longint'(gain_step_q);
    gain_q = clamp(gain_q, 0, ONE);

    drv = up ? bias_q + gain_q : bias_q - gain_q;
    drv = clamp(drv, 0, ONE);

    r.drive     = LVL_W'(drv);
    r.bias_now  = LVL_W'(bias_q);
    r.gain_now  = LVL_W'(gain_q);
    r.error_now = ERR_W'(e);
    expected_words.push_back(r);
  endfunction

  task automatic report_mismatch(input string what, input longint got, input longint want);
    $display("[%0t] mismatch on %s: got %0d, expected %0d", $time, what, got, want);
    fail_count++;
  endtask

  // Result side: each accepted word is checked against the oldest expectation.
  always @(posedge clk) begin : result_check
    tick_result_t want;
    if (rst_n === 1'b1 && out_if.valid === 1'b1 && out_if.ready === 1'b1) begin
      if (expected_words.size() == 0) begin
        report_mismatch("result word with nothing expected (drive)", out_if.drive, 0);
      end else begin
        want = expected_words.pop_front();
        if (out_if.drive !== want.drive)
          report_mismatch("drive", out_if.drive, want.drive);
        if (out_if.bias_now !== want.bias_now)
          report_mismatch("bias_now", out_if.bias_now, want.bias_now);
        if (out_if.gain_now !== want.gain_now)
          report_mismatch("gain_now", out_if.gain_now, want.gain_now);
        if (out_if.error_now !== want.error_now)
          report_mismatch("error_now", out_if.error_now, want.error_now);
      end
    end
  end

  // Ready on the result side. A requested hold-off is counted down here, one
  // cycle at a time; otherwise the receiver idles at random when allowed.
  initial out_if.ready = 1'b0;
  always @(negedge clk) begin
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_if.ready <= 1'b0;
    end else if (idle_en && $urandom_range(99) < IDLE_PCT) begin
      out_if.ready <= 1'b0;
    end else begin
      out_if.ready <= 1'b1;
    end
  end

  // Watchdog: a hang anywhere ends the run as a failure.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("[adaptive_bias_gain_controller_core] ERROR");
      $finish;
    end
  end

  // Offers one measurement word and waits for it to be taken. Called and
  // returning at a falling edge. Valid is left high, so that back-to-back
  // words keep it high; the caller lowers it when the stream stops.
  task automatic send_measurement(input logic [MEAS_WIDTH-1:0] m);
    while (idle_en && $urandom_range(99) < IDLE_PCT) begin
      in_if.valid <= 1'b0;
      @(negedge clk);
    end
    in_if.valid <= 1'b1;
    in_if.measurement <= m;
    do @(posedge clk); while (in_if.ready !== 1'b1);
    predict_tick(m);
    @(negedge clk);
  endtask

  // Writes one register; unknown indexes leave the predictor untouched.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] value);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= value;
    do @(posedge clk); while (cfg_if.ready !== 1'b1);
    case (idx)
      abag_pkg::REG_SETPOINT:  setp_q      = value[SETP_W-1:0];
      abag_pkg::REG_ALPHA:     alpha_q     = value[ALPHA_W-1:0];
      abag_pkg::REG_BIAS_BAND: bias_band_q = value;
      abag_pkg::REG_GAIN_BAND: gain_band_q = value;
      abag_pkg::REG_BIAS_STEP: bias_step_q = value;
      abag_pkg::REG_GAIN_STEP: gain_step_q = value;
      default: ;
    endcase
    @(negedge clk);
    cfg_if.valid <= 1'b0;
    @(negedge clk);
  endtask

  // Stops offering words and waits until every expected result word has been
  // taken, then lets the two pipeline stages settle.
  task automatic wait_drained();
    in_if.valid <= 1'b0;
    while (expected_words.size() != 0) @(posedge clk);
    repeat (6) @(posedge clk);
    @(negedge clk);
  endtask

  // A measurement on a chosen side of the setpoint; "below" includes equality,
  // since only a strictly greater measurement gives a positive sign.
  function automatic logic [MEAS_WIDTH-1:0] side_value(input bit up);
    if (up && setp_q != '1)
      return MEAS_WIDTH'($urandom_range(int'(setp_q) + 1, (1 << MEAS_WIDTH) - 1));
    if ($urandom_range(15) == 0)
      return setp_q;
    return MEAS_WIDTH'($urandom_range(0, int'(setp_q)));
  endfunction

  // A band or step value; extremes come up often, including values past 1.0.
  function automatic logic [LVL_W-1:0] rand_level(input int unsigned typical_max);
    case ($urandom_range(9))
      0: return '0;
      1: return LVL_W'(ONE);
      2: return '1;
      3: return LVL_W'($urandom);
      default: return LVL_W'($urandom_range(typical_max));
    endcase
  endfunction

  // Registers at their defaults straight after reset, with the measurement at
  // its extremes and equal to the setpoint.
  task automatic test_power_on_defaults();
    send_measurement('0);
    send_measurement('1);
    send_measurement('1);
    send_measurement(MEAS_WIDTH'(1));
    send_measurement('0);
    send_measurement('0);
    send_measurement('1);
    send_measurement('0);
  endtask

  // Every register at its extremes, data bits above a register's width, and
  // writes to indexes that the core does not decode.
  task automatic test_register_extremes();
    wait_drained();
    write_reg(abag_pkg::REG_SETPOINT, 17'h1_8000);   // bit 16 must be dropped
    write_reg(abag_pkg::REG_ALPHA, '0);              // filter follows the sign at once
    write_reg(abag_pkg::REG_BIAS_BAND, '0);
    write_reg(abag_pkg::REG_GAIN_BAND, '0);
    write_reg(abag_pkg::REG_BIAS_STEP, '1);          // steps beyond one saturate
    write_reg(abag_pkg::REG_GAIN_STEP, '1);
    send_measurement(16'h8000);
    send_measurement(16'h8001);
    send_measurement('0);
    send_measurement('1);
    wait_drained();
    write_reg(REG_SPARE_LO, '1);
    write_reg(REG_SPARE_HI, '0);
    send_measurement(16'h8001);
    send_measurement(16'h8000);
    wait_drained();
    write_reg(abag_pkg::REG_SETPOINT, '1);           // nothing can lie above it
    write_reg(abag_pkg::REG_ALPHA, '1);              // slowest filter allowed
    write_reg(abag_pkg::REG_BIAS_BAND, '1);
    write_reg(abag_pkg::REG_GAIN_BAND, LVL_W'(ONE));
    write_reg(abag_pkg::REG_BIAS_STEP, LVL_W'(1));
    write_reg(abag_pkg::REG_GAIN_STEP, LVL_W'(1));
    send_measurement('1);
    send_measurement('0);
    send_measurement(16'h7FFF);
    wait_drained();
    write_reg(abag_pkg::REG_SETPOINT, '0);
    write_reg(abag_pkg::REG_ALPHA, LVL_W'(ONE / 2));
    send_measurement('0);
    send_measurement(MEAS_WIDTH'(1));
    send_measurement('1);
  endtask

  // One phase of random settings followed by runs of measurements on one side
  // of the setpoint, so that the filtered error swings through both bands,
  // with some words of noise mixed in.
  task automatic test_run_phase(input bit gaps, input int n_words);
    int remaining;
    int run_len;
    bit up;
    wait_drained();
    idle_en = gaps;
    case ($urandom_range(3))
      0: write_reg(abag_pkg::REG_SETPOINT, '0);
      1: write_reg(abag_pkg::REG_SETPOINT, LVL_W'(16'hFFFF));
      default: write_reg(abag_pkg::REG_SETPOINT, LVL_W'($urandom_range(16'hFFFF)));
    endcase
    case ($urandom_range(4))
      0: write_reg(abag_pkg::REG_ALPHA, '0);
      1: write_reg(abag_pkg::REG_ALPHA, LVL_W'(16'hFFFF));
      2: write_reg(abag_pkg::REG_ALPHA, LVL_W'($urandom_range(16'hFFFF)));
      default: write_reg(abag_pkg::REG_ALPHA, LVL_W'($urandom_range(16'hE000, 16'h4000)));
    endcase
    write_reg(abag_pkg::REG_BIAS_BAND, rand_level(ONE));
    write_reg(abag_pkg::REG_GAIN_BAND, rand_level(ONE));
    write_reg(abag_pkg::REG_BIAS_STEP, rand_level(4096));
    write_reg(abag_pkg::REG_GAIN_STEP, rand_level(4096));
    remaining = n_words;
    while (remaining > 0) begin
      run_len = $urandom_range(1, 30);
      up = $urandom_range(1);
      for (int k = 0; k < run_len && remaining > 0; k++) begin
        if ($urandom_range(9) == 0)
          send_measurement(MEAS_WIDTH'($urandom));
        else
          send_measurement(side_value(up));
        remaining--;
      end
    end
  endtask

  // The receiver holds off for a long stretch while the sender keeps offering
  // words, so the core fills up and has to stall its input.
  task automatic test_output_stall();
    wait_drained();
    idle_en = 1'b0;
    stall_left = 300;
    for (int k = 0; k < 60; k++)
      send_measurement(side_value(k % 20 < 10));
    idle_en = 1'b1;
  endtask

  // The sender stops until every expected word has come, then carries on; the
  // state must carry over the pause unchanged.
  task automatic test_sender_pause();
    for (int k = 0; k < 20; k++)
      send_measurement(side_value(k % 8 < 5));
    wait_drained();
    for (int k = 0; k < 20; k++)
      send_measurement(side_value(k % 6 < 2));
  endtask

  initial begin
    rst_n = 1'b0;
    in_if.valid = 1'b0;
    in_if.measurement = '0;
    cfg_if.valid = 1'b0;
    cfg_if.index = '0;
    cfg_if.data = '0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    test_power_on_defaults();
    test_register_extremes();
    test_run_phase(1'b1, 160);
    test_run_phase(1'b0, 160);   // a long stretch with no idling on either side
    test_run_phase(1'b1, 160);
    test_output_stall();
    test_run_phase(1'b1, 160);
    test_sender_pause();
    test_run_phase(1'b1, 160);
    test_run_phase(1'b1, 160);

    wait_drained();
    repeat (10) @(posedge clk);
    if (fail_count == 0) begin
      $display("[adaptive_bias_gain_controller_core] OK");
    end else begin
      $display("[adaptive_bias_gain_controller_core] ERROR");
    end
    $finish;
  end

endmodule
